[rtl/pixel_block_injection_scanner_top_defines.svh]
// Assertion macros used by the pixel block injection scanner top level.
`ifndef PIXEL_BLOCK_INJECTION_SCANNER_TOP_DEFINES_SVH
`define PIXEL_BLOCK_INJECTION_SCANNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PBIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbis check failed");
`define PBIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbis check failed");
`else
`define PBIS_ASSERT_SAME(label, ante, cons)
`define PBIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/pbis_pkg.sv]
// Types and constants of the pixel block injection scanner.
`timescale 1ns / 1ps
package pbis_pkg;

    localparam int C_NUM_COLUMNS = 256;
    localparam int C_NUM_ROWS    = 250;

    localparam logic [2:0] CFG_DEVICE_TYPE  = 3'd0;
    localparam logic [2:0] CFG_FIRST_COLUMN = 3'd1;
    localparam logic [2:0] CFG_LAST_COLUMN  = 3'd2;
    localparam logic [2:0] CFG_FIRST_ROW    = 3'd3;
    localparam logic [2:0] CFG_LAST_ROW     = 3'd4;

    localparam logic [1:0] DEV_VERTEX = 2'd1;
    localparam logic [1:0] DEV_OUTER  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MAIN,
        PH_RIGHT,
        PH_BOTTOM,
        PH_CORNER
    } t_phase;

    typedef struct packed {
        logic [7:0] first_column;
        logic [7:0] last_column;
        logic [7:0] first_row;
        logic [7:0] last_row;
    } t_bounds;

    // Scan geometry derived from the configuration registers.
    typedef struct packed {
        logic       ok;       // known device type
        logic       vertex;   // 4x3 steps with paired columns
        logic [7:0] nc;       // main column stripes
        logic [7:0] nr;       // main row blocks
        logic [1:0] rcol;     // leftover columns
        logic [1:0] rrow;     // leftover rows
        logic       at_edge;  // last stripe sits at the right edge of the matrix
    } t_geom;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] col_cur;
        logic [7:0] row_cur;
    } t_scan;

    typedef struct packed {
        logic [7:0] col_first;
        logic [7:0] col_second;
        logic [1:0] col_count;
        logic [7:0] row_first;
        logic [7:0] row_last;
        logic       block_valid;
    } t_block;

endpackage

[rtl/pbis_geom.sv]
// Registered scan geometry computed from the configuration registers.
`timescale 1ns / 1ps
module pbis_geom
    import pbis_pkg::*;
(
    input  logic       i_clk,
    input  logic [1:0] i_device_type,
    input  t_bounds    i_bounds,
    output t_geom      o_geom
);

    localparam logic signed [9:0] CAP_C4 = 10'(C_NUM_COLUMNS - 4);
    localparam logic signed [9:0] CAP_C2 = 10'(C_NUM_COLUMNS - 2);
    localparam logic signed [9:0] CAP_R3 = 10'(C_NUM_ROWS - 3);
    localparam logic signed [9:0] CAP_R2 = 10'(C_NUM_ROWS - 2);

    // Exact for every 8-bit value.
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        prod = {8'd0, x} * 16'd171;
        return {1'b0, prod[15:9]};
    endfunction

    logic              vertex;
    logic              outer;
    logic signed [9:0] col_hi_raw, col_cap, col_hi, col_lo;
    logic signed [9:0] row_hi_raw, row_cap, row_hi, row_lo;
    logic              col_ge, row_ge;
    logic [7:0]        col_diff, row_diff;
    logic [7:0]        cspan, rspan, rspan_q3;
    logic [1:0]        rspan_m3;
    t_geom             n_geom;
    t_geom             r_geom;

    always_comb begin
        vertex = (i_device_type == DEV_VERTEX);
        outer  = (i_device_type == DEV_OUTER);

        col_lo     = $signed({2'b00, i_bounds.first_column});
        col_hi_raw = $signed({2'b00, i_bounds.last_column}) + 10'sd1
                     - (vertex ? 10'sd4 : 10'sd2);
        col_cap    = vertex ? CAP_C4 : CAP_C2;
        col_hi     = (col_hi_raw > col_cap) ? col_cap : col_hi_raw;
        col_ge     = (col_hi >= col_lo);
        col_diff   = 8'(col_hi - col_lo);

        row_lo     = $signed({2'b00, i_bounds.first_row});
        row_hi_raw = $signed({2'b00, i_bounds.last_row}) + 10'sd1
                     - (vertex ? 10'sd3 : 10'sd2);
        row_cap    = vertex ? CAP_R3 : CAP_R2;
        row_hi     = (row_hi_raw > row_cap) ? row_cap : row_hi_raw;
        row_ge     = (row_hi >= row_lo);
        row_diff   = 8'(row_hi - row_lo);

        cspan    = i_bounds.last_column - i_bounds.first_column;
        rspan    = i_bounds.last_row - i_bounds.first_row;
        rspan_q3 = div3(rspan);
        rspan_m3 = 2'(rspan - 8'({rspan_q3, 1'b0} + {1'b0, rspan_q3}));

        n_geom = '0;
        if (vertex || outer) begin
            n_geom.ok     = 1'b1;
            n_geom.vertex = vertex;
            if (col_ge) begin
                n_geom.nc = (vertex ? {2'b00, col_diff[7:2]} : {1'b0, col_diff[7:1]})
                            + 8'd1;
            end
            if (row_ge) begin
                n_geom.nr = (vertex ? div3(row_diff) : {1'b0, row_diff[7:1]}) + 8'd1;
            end
            // The last stripe touches the edge when the clamped top is hit exactly.
            n_geom.at_edge = col_ge && (col_hi == col_cap)
                             && (vertex ? (col_diff[1:0] == 2'b00) : !col_diff[0]);
            if (vertex) begin
                n_geom.rcol = cspan[1:0] + 2'd1;
                n_geom.rrow = (rspan_m3 == 2'd2) ? 2'd0 : rspan_m3 + 2'd1;
            end else begin
                n_geom.rcol = {1'b0, ~cspan[0]};
                n_geom.rrow = {1'b0, ~rspan[0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

[rtl/pbis_step.sv]
// Next scan position and block descriptor for one request.
`timescale 1ns / 1ps
module pbis_step
    import pbis_pkg::*;
(
    input  t_geom   i_geom,
    input  t_bounds i_bounds,
    input  t_scan   i_scan,
    input  logic    i_mode,
    input  logic    i_keep_going,
    output t_scan   o_scan,
    output t_block  o_block,
    output logic    o_more
);

    logic [8:0] k1;
    logic       k_ok, j_ok, k1_ok;
    logic       nr_nz, nc_nz, rc_nz, rr_nz;
    logic       edge_k, edge_k1;
    logic       active, ph_main, ph_right, ph_bottom, ph_corner;
    logic       main_emit, main_abort, fall_right, use_k1;
    logic [7:0] s_col, s_row;
    logic       s_edge;
    logic [8:0] j_next;
    logic       stripe_done;
    logic       main_go, t_right, right_emit, t_bottom, bottom_emit, t_corner, corner_emit;
    logic [7:0] tj, tk;
    logic [7:0] col_idx, row_idx, col_pos, row_pos;
    logic [8:0] row3_w;
    logic [7:0] tc0, tc1, tr0;
    logic [1:0] tcnt;

    always_comb begin
        k1      = {1'b0, i_scan.col_cur} + 9'd1;
        k_ok    = (i_scan.col_cur < i_geom.nc);
        j_ok    = (i_scan.row_cur < i_geom.nr);
        k1_ok   = (k1 < {1'b0, i_geom.nc});
        nr_nz   = |i_geom.nr;
        nc_nz   = |i_geom.nc;
        rc_nz   = |i_geom.rcol;
        rr_nz   = |i_geom.rrow;
        edge_k  = i_geom.at_edge && (k1 == {1'b0, i_geom.nc});
        edge_k1 = i_geom.at_edge && ((k1 + 9'd1) == {1'b0, i_geom.nc});

        active    = i_mode && i_geom.ok;
        ph_main   = (i_scan.phase == PH_MAIN);
        ph_right  = (i_scan.phase == PH_RIGHT);
        ph_bottom = (i_scan.phase == PH_BOTTOM);
        ph_corner = (i_scan.phase == PH_CORNER);
    end

    // Main scan: a row cursor beyond its range closes the stripe first. Stripes
    // without row blocks are all passed in one request unless keep_going stops it.
    always_comb begin
        main_emit  = 1'b0;
        main_abort = 1'b0;
        fall_right = 1'b0;
        use_k1     = 1'b0;
        if (!k_ok) begin
            fall_right = 1'b1;
        end else if (j_ok) begin
            main_emit = 1'b1;
        end else if (!i_keep_going && !edge_k) begin
            main_abort = 1'b1;
        end else if (nr_nz) begin
            if (k1_ok) begin
                main_emit = 1'b1;
                use_k1    = 1'b1;
            end else begin
                fall_right = 1'b1;
            end
        end else if (!i_keep_going && k1_ok && !edge_k1) begin
            main_abort = 1'b1;
        end else begin
            fall_right = 1'b1;
        end

        s_col       = use_k1 ? k1[7:0] : i_scan.col_cur;
        s_row       = use_k1 ? 8'd0 : i_scan.row_cur;
        s_edge      = use_k1 ? edge_k1 : edge_k;
        j_next      = {1'b0, s_row} + 9'd1;
        stripe_done = (j_next >= {1'b0, i_geom.nr});
    end

    // Strips and corner after the main scan.
    always_comb begin
        main_go     = active && ph_main && main_emit;
        t_right     = active && ((ph_main && fall_right) || ph_right);
        tj          = ph_right ? i_scan.row_cur : 8'd0;
        right_emit  = t_right && rc_nz && (tj < i_geom.nr);
        t_bottom    = (t_right && !right_emit) || (active && ph_bottom);
        tk          = ph_bottom ? i_scan.col_cur : 8'd0;
        bottom_emit = t_bottom && rr_nz && (tk < i_geom.nc);
        t_corner    = (t_bottom && !bottom_emit) || (active && ph_corner);
        corner_emit = t_corner && rc_nz && rr_nz;
    end

    always_comb begin
        col_idx = main_go ? s_col : tk;
        row_idx = main_go ? s_row : tj;
        row3_w  = {row_idx, 1'b0} + {1'b0, row_idx};
        col_pos = i_bounds.first_column
                  + (i_geom.vertex ? {col_idx[5:0], 2'b00} : {col_idx[6:0], 1'b0});
        row_pos = i_bounds.first_row
                  + (i_geom.vertex ? row3_w[7:0] : {row_idx[6:0], 1'b0});

        tc1  = 8'd0;
        tcnt = 2'd1;
        case (i_geom.rcol)
            2'd1: tc0 = i_bounds.last_column;
            2'd2: tc0 = i_bounds.last_column - 8'd1;
            default: begin
                tc0  = i_bounds.last_column - 8'd2;
                tc1  = i_bounds.last_column;
                tcnt = 2'd2;
            end
        endcase
        tr0 = (i_geom.rrow == 2'd2) ? i_bounds.last_row - 8'd1 : i_bounds.last_row;

        o_block = '0;
        if (main_go || right_emit || bottom_emit || corner_emit) begin
            o_block.block_valid = 1'b1;
            if (right_emit || corner_emit) begin
                o_block.col_first  = tc0;
                o_block.col_second = tc1;
                o_block.col_count  = tcnt;
            end else begin
                o_block.col_first  = col_pos;
                o_block.col_second = i_geom.vertex ? col_pos + 8'd2 : 8'd0;
                o_block.col_count  = i_geom.vertex ? 2'd2 : 2'd1;
            end
            if (bottom_emit || corner_emit) begin
                o_block.row_first = tr0;
                o_block.row_last  = i_bounds.last_row;
            end else begin
                o_block.row_first = row_pos;
                o_block.row_last  = row_pos + (i_geom.vertex ? 8'd2 : 8'd1);
            end
        end
    end

    always_comb begin
        o_scan = i_scan;
        if (!i_mode) begin
            o_scan.phase   = i_geom.ok ? PH_MAIN : PH_IDLE;
            o_scan.col_cur = 8'd0;
            o_scan.row_cur = 8'd0;
        end else if (main_go) begin
            if (stripe_done) begin
                if (!i_keep_going && !s_edge) begin
                    o_scan.phase = PH_IDLE;
                end else begin
                    o_scan.phase   = PH_MAIN;
                    o_scan.col_cur = s_col + 8'd1;
                    o_scan.row_cur = 8'd0;
                end
            end else begin
                o_scan.phase   = PH_MAIN;
                o_scan.col_cur = s_col;
                o_scan.row_cur = j_next[7:0];
            end
        end else if (right_emit) begin
            o_scan.phase   = PH_RIGHT;
            o_scan.row_cur = tj + 8'd1;
        end else if (bottom_emit) begin
            o_scan.phase   = PH_BOTTOM;
            o_scan.col_cur = tk + 8'd1;
        end else begin
            o_scan.phase = PH_IDLE;
        end
    end

    // Whether a block would still follow from the present position.
    always_comb begin
        case (i_scan.phase)
            PH_MAIN:   o_more = (nr_nz && ((k_ok && j_ok) || k1_ok)) || (rc_nz && nr_nz)
                                || (rr_nz && nc_nz) || (rc_nz && rr_nz);
            PH_RIGHT:  o_more = (rc_nz && j_ok) || (rr_nz && nc_nz) || (rc_nz && rr_nz);
            PH_BOTTOM: o_more = (rr_nz && k_ok) || (rc_nz && rr_nz);
            PH_CORNER: o_more = rc_nz && rr_nz;
            default:   o_more = 1'b0;
        endcase
        o_more = o_more && i_geom.ok;
    end

endmodule

[rtl/pixel_block_injection_scanner_top.sv]
// Top level of the pixel block injection scanner.
//
// Requests come in on the s_axis channel: tuser is the mode (0 starts a new
// scan, 1 asks for the next block), tdata bit 0 is keep_going. Every request
// gives one result on the m_axis channel: tdata carries the block, tuser says
// whether a block is present and tlast marks the end of the scan.
// Registers are written on the cfg channel, which is always ready; the user
// must write them only while no request is in flight, which the block does
// not enforce. A request passes the first stage and then the output register;
// one request is taken per cycle unless the output stalls or a write settles:
// the position step is one pass of logic behind the scan registers, and the
// end-of-scan flag is formed from the updated position in the next stage. After
// a write or reset, requests are held off while the geometry register reloads.
// Reset loads the default rectangle with an unknown device type and leaves
// the scan finished. When the receiver stalls, one result waits in the output
// register and one more in the stage before it; then s_axis_tready drops.
`timescale 1ns / 1ps
`include "pixel_block_injection_scanner_top_defines.svh"
module pixel_block_injection_scanner_top
    import pbis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] keep_going, [7:1] zero
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] col_first, [15:8] col_second, [17:16] col_count, [25:18] row_first,
    // [33:26] row_last, [39:34] zero
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] block_valid
    output logic        m_axis_tlast,   // scan_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [1:0] r_device_type, n_device_type;
    t_bounds    r_bounds, n_bounds;
    logic       r_settle;
    t_scan      r_scan, n_scan;
    logic       r_s1_valid, n_s1_valid;
    t_block     r_s1_blk;
    logic       r_s1_more;
    logic       r_out_valid, n_out_valid;
    t_block     r_out_blk;
    logic       r_out_done;

    t_geom      geom;
    t_scan      step_scan;
    t_block     step_blk;
    logic       step_more;
    logic       cfg_wr, in_acc, out_free, s1_move;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && out_free;
    assign s_axis_tready = !r_settle && (!r_s1_valid || s1_move);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    pbis_geom u_geom (
        .i_clk         (i_clk),
        .i_device_type (r_device_type),
        .i_bounds      (r_bounds),
        .o_geom        (geom)
    );

    pbis_step u_step (
        .i_geom       (geom),
        .i_bounds     (r_bounds),
        .i_scan       (r_scan),
        .i_mode       (s_axis_tuser),
        .i_keep_going (s_axis_tdata[0]),
        .o_scan       (step_scan),
        .o_block      (step_blk),
        .o_more       (step_more)
    );

    always_comb begin
        n_device_type = r_device_type;
        n_bounds      = r_bounds;
        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_DEVICE_TYPE:  n_device_type         = i_cfg_data[1:0];
                CFG_FIRST_COLUMN: n_bounds.first_column = i_cfg_data;
                CFG_LAST_COLUMN:  n_bounds.last_column  = i_cfg_data;
                CFG_FIRST_ROW:    n_bounds.first_row    = i_cfg_data;
                CFG_LAST_ROW:     n_bounds.last_row     = i_cfg_data;
                default: ;
            endcase
        end

        n_scan      = in_acc ? step_scan : r_scan;
        n_s1_valid  = in_acc || (r_s1_valid && !s1_move);
        n_out_valid = s1_move || (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_type         <= 2'd0;
            r_bounds.first_column <= 8'd0;
            r_bounds.last_column  <= 8'd255;
            r_bounds.first_row    <= 8'd0;
            r_bounds.last_row     <= 8'd249;
            r_settle              <= 1'b1;
            r_scan.phase          <= PH_IDLE;
            r_scan.col_cur        <= 8'd0;
            r_scan.row_cur        <= 8'd0;
            r_s1_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            r_device_type <= n_device_type;
            r_bounds      <= n_bounds;
            r_settle      <= cfg_wr;
            r_scan        <= n_scan;
            r_s1_valid    <= n_s1_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // A next-block request that gives no block needs no look-ahead: the scan is over.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_blk  <= step_blk;
            r_s1_more <= step_blk.block_valid || !s_axis_tuser;
        end
        if (s1_move) begin
            r_out_blk  <= r_s1_blk;
            r_out_done <= r_s1_more ? !step_more : 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_blk.row_last, r_out_blk.row_first,
                            r_out_blk.col_count, r_out_blk.col_second, r_out_blk.col_first};
    assign m_axis_tuser  = r_out_blk.block_valid;
    assign m_axis_tlast  = r_out_done;

    `PBIS_ASSERT_SAME(a_empty_result_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 40'd0)
    `PBIS_ASSERT_SAME(a_block_count, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[17:16] == 2'd1) || (m_axis_tdata[17:16] == 2'd2))
    `PBIS_ASSERT_NEXT(a_request_held, s_axis_tvalid && s_axis_tready, r_s1_valid)
    `PBIS_ASSERT_NEXT(a_cfg_settles, i_cfg_valid && o_cfg_ready, !s_axis_tready)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the pixel block injection scanner top level.
`timescale 1ns / 1ps
module tb_top;
    import pbis_pkg::*;

    localparam bit MODE_START = 1'b0;
    localparam bit MODE_NEXT  = 1'b1;

    localparam logic [1:0] DEV_UNKNOWN  = 2'd0;
    localparam logic [1:0] DEV_RESERVED = 2'd3;

    localparam int RANDOM_REQUESTS = 1450;

    typedef struct packed {
        bit [7:0] col_first;
        bit [7:0] col_second;
        bit [1:0] col_count;
        bit [7:0] row_first;
        bit [7:0] row_last;
        bit       block_valid;
        bit       scan_done;
    } block_result_t;

    typedef struct packed {
        int col_step;
        int row_step;
        int n_stripes;
        int n_rowblk;
        int tail_cols;
        int tail_rows;
        bit paired;
    } scan_layout_t;

    typedef struct packed {
        bit            is_reg;
        bit [2:0]      reg_idx;
        bit [7:0]      reg_val;
        bit            mode;
        bit            kg;
        bit            typed;
        block_result_t want;
    } plan_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] keep_going, [7:1] zero
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] col_first, [15:8] col_second, [17:16] col_count, [25:18] row_first,
    // [33:26] row_last, [39:34] zero
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;   // [0] block_valid
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    // Predictor copy of the registers and the scan position.
    bit [1:0]  reg_dev;
    bit [7:0]  reg_col_lo, reg_col_hi, reg_row_lo, reg_row_hi;
    t_phase    scan_state;
    bit [7:0]  stripe_idx, rowblk_idx;

    block_result_t expected_blocks[$];
    block_result_t last_result;
    plan_row_t     plan[$];

    int src_idle_pct;
    int dst_stall_pct;
    int mismatches;
    int requests_sent;
    int blocks_predicted;
    int scan_ends_seen;
    int settings_used;

    pixel_block_injection_scanner_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int steps_in(int lo, int hi, int stride, int span);
        int top;
        top = hi - stride + 1;
        if (top > span - stride) top = span - stride;
        return (top >= lo) ? (top - lo) / stride + 1 : 0;
    endfunction

    function automatic bit layout_of(output scan_layout_t g);
        bit [7:0] col_span, row_span;
        col_span = reg_col_hi - reg_col_lo;
        row_span = reg_row_hi - reg_row_lo;
        g = '0;
        if (reg_dev == DEV_VERTEX) begin
            g.col_step  = 4;
            g.row_step  = 3;
            g.paired    = 1'b1;
            g.tail_cols = ((col_span % 4) + 1) % 4;
            g.tail_rows = ((row_span % 3) + 1) % 3;
        end else if (reg_dev == DEV_OUTER) begin
            g.col_step  = 2;
            g.row_step  = 2;
            g.paired    = 1'b0;
            g.tail_cols = ((col_span % 2) + 1) % 2;
            g.tail_rows = ((row_span % 2) + 1) % 2;
        end else begin
            return 1'b0;
        end
        g.n_stripes = steps_in(reg_col_lo, reg_col_hi, g.col_step, C_NUM_COLUMNS);
        g.n_rowblk  = steps_in(reg_row_lo, reg_row_hi, g.row_step, C_NUM_ROWS);
        return 1'b1;
    endfunction

    function automatic block_result_t make_block(int c0, int c1, int cnt, int r0, int r1);
        block_result_t b;
        b = '0;
        b.col_first   = c0[7:0];
        b.col_second  = c1[7:0];
        b.col_count   = cnt[1:0];
        b.row_first   = r0[7:0];
        b.row_last    = r1[7:0];
        b.block_valid = 1'b1;
        return b;
    endfunction

    // Leftover columns at the right edge of the rectangle against a row span.
    function automatic block_result_t tail_block(scan_layout_t g, int r0, int r1);
        if (g.tail_cols == 1) return make_block(reg_col_hi, 0, 1, r0, r1);
        if (g.tail_cols == 2) return make_block(reg_col_hi - 1, 0, 1, r0, r1);
        return make_block(reg_col_hi - 2, reg_col_hi, 2, r0, r1);
    endfunction

    function automatic int tail_row_first(scan_layout_t g);
        return (g.tail_rows == 2) ? reg_row_hi - 1 : reg_row_hi;
    endfunction

    // A stripe that ends short of the right edge of the matrix aborts the scan
    // when keep_going is low.
    function automatic bit close_stripe(scan_layout_t g, int c, bit kg);
        if (c != C_NUM_COLUMNS - g.col_step && !kg) begin
            scan_state = PH_IDLE;
            return 1'b0;
        end
        stripe_idx++;
        rowblk_idx = 0;
        return 1'b1;
    endfunction

    function automatic bit advance_scan(bit kg, output block_result_t b);
        scan_layout_t g;
        int c, r;
        b = '0;
        if (!layout_of(g)) begin
            scan_state = PH_IDLE;
            return 1'b0;
        end
        for (int guard = 0; guard < 400; guard++) begin
            case (scan_state)
                PH_MAIN: begin
                    if (stripe_idx >= g.n_stripes) begin
                        scan_state = PH_RIGHT;
                        rowblk_idx = 0;
                    end else begin
                        c = reg_col_lo + stripe_idx * g.col_step;
                        if (rowblk_idx < g.n_rowblk) begin
                            r = reg_row_lo + rowblk_idx * g.row_step;
                            b = make_block(c, g.paired ? c + 2 : 0, g.paired ? 2 : 1,
                                           r, r + g.row_step - 1);
                            rowblk_idx++;
                            if (rowblk_idx >= g.n_rowblk) void'(close_stripe(g, c, kg));
                            return 1'b1;
                        end
                        if (!close_stripe(g, c, kg)) return 1'b0;
                    end
                end
                PH_RIGHT: begin
                    if (g.tail_cols == 0 || rowblk_idx >= g.n_rowblk) begin
                        scan_state = PH_BOTTOM;
                        stripe_idx = 0;
                    end else begin
                        r = reg_row_lo + rowblk_idx * g.row_step;
                        b = tail_block(g, r, r + g.row_step - 1);
                        rowblk_idx++;
                        return 1'b1;
                    end
                end
                PH_BOTTOM: begin
                    if (g.tail_rows == 0 || stripe_idx >= g.n_stripes) begin
                        scan_state = PH_CORNER;
                    end else begin
                        c = reg_col_lo + stripe_idx * g.col_step;
                        b = make_block(c, g.paired ? c + 2 : 0, g.paired ? 2 : 1,
                                       tail_row_first(g), reg_row_hi);
                        stripe_idx++;
                        return 1'b1;
                    end
                end
                PH_CORNER: begin
                    scan_state = PH_IDLE;
                    if (g.tail_cols != 0 && g.tail_rows != 0) begin
                        b = tail_block(g, tail_row_first(g), reg_row_hi);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: begin
                    scan_state = PH_IDLE;
                    return 1'b0;
                end
            endcase
        end
        scan_state = PH_IDLE;
        return 1'b0;
    endfunction

    // Looks one block ahead with keep_going high and leaves the position as it was.
    function automatic bit more_left();
        t_phase        p;
        bit [7:0]      k, j;
        block_result_t scratch;
        bit            found;
        p = scan_state;
        k = stripe_idx;
        j = rowblk_idx;
        found = advance_scan(1'b1, scratch);
        scan_state = p;
        stripe_idx = k;
        rowblk_idx = j;
        return found;
    endfunction

    function automatic block_result_t predict_block(bit mode, bit kg);
        block_result_t res;
        scan_layout_t  g;
        res = '0;
        if (mode == MODE_START) begin
            stripe_idx = 0;
            rowblk_idx = 0;
            scan_state = layout_of(g) ? PH_MAIN : PH_IDLE;
            res.scan_done = !more_left();
        end else if (advance_scan(kg, res)) begin
            res.scan_done = !more_left();
        end else begin
            res = '0;
            res.scan_done = 1'b1;
        end
        return res;
    endfunction

    function automatic void apply_register(bit [2:0] idx, bit [7:0] val);
        case (idx)
            CFG_DEVICE_TYPE:  reg_dev    = val[1:0];
            CFG_FIRST_COLUMN: reg_col_lo = val;
            CFG_LAST_COLUMN:  reg_col_hi = val;
            CFG_FIRST_ROW:    reg_row_lo = val;
            CFG_LAST_ROW:     reg_row_hi = val;
            default: ;
        endcase
    endfunction

    function automatic plan_row_t reg_row(bit [2:0] idx, bit [7:0] val);
        plan_row_t row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic plan_row_t req_row(bit mode, bit kg);
        plan_row_t row;
        row = '0;
        row.mode = mode;
        row.kg   = kg;
        return row;
    endfunction

    function automatic plan_row_t idle_row(bit mode, bit kg, bit done);
        plan_row_t row;
        row = req_row(mode, kg);
        row.typed          = 1'b1;
        row.want.scan_done = done;
        return row;
    endfunction

    function automatic plan_row_t known_row(bit mode, bit kg, int c0, int c1, int cnt,
                                            int r0, int r1, bit done);
        plan_row_t row;
        row = req_row(mode, kg);
        row.typed          = 1'b1;
        row.want           = make_block(c0, c1, cnt, r0, r1);
        row.want.scan_done = done;
        return row;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the request.
    task automatic send_request(input bit mode, input bit kg, input bit use_known,
                                input block_result_t known);
        block_result_t guess;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'b0, kg};
        do @(posedge i_clk); while (!s_axis_tready);
        guess = predict_block(mode, kg);
        expected_blocks.push_back(use_known ? known : guess);
        last_result = guess;
        requests_sent++;
        if (guess.block_valid) blocks_predicted++;
        if (guess.scan_done) scan_ends_seen++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_session(input int sid);
        bit [1:0] dev;
        bit [7:0] fc, lc, fr, lr;
        int       w, quota, after_done, pick;
        case (sid % 4)
            0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1:       begin src_idle_pct = 70; dst_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  dst_stall_pct = 70; end
            default: begin src_idle_pct = 12; dst_stall_pct = 12; end
        endcase
        pick = $urandom_range(19);
        if (pick == 0)       dev = DEV_UNKNOWN;
        else if (pick == 1)  dev = DEV_RESERVED;
        else if (pick < 11)  dev = DEV_VERTEX;
        else                 dev = DEV_OUTER;
        case ($urandom_range(9))
            0: begin
                fc = 8'd0;
                lc = 8'd255;
                fr = 8'd0;
                lr = 8'd249;
            end
            1: begin
                // Rectangle pushed against the right and bottom edges of the matrix.
                fc = $urandom_range(240, 255);
                lc = 8'd255;
                fr = $urandom_range(235, 249);
                lr = 8'd249;
            end
            2: begin
                fc = $urandom_range(255);
                lc = $urandom_range(255);
                fr = $urandom_range(249);
                lr = $urandom_range(249);
            end
            default: begin
                fc = $urandom_range(255);
                lc = fc + $urandom_range(14);
                fr = $urandom_range(249);
                w  = fr + $urandom_range(14);
                lr = (w > 249) ? w - 250 : w;
            end
        endcase
        wait_idle();
        write_reg(CFG_DEVICE_TYPE, {6'b0, dev});
        write_reg(CFG_FIRST_COLUMN, fc);
        write_reg(CFG_LAST_COLUMN, lc);
        write_reg(CFG_FIRST_ROW, fr);
        write_reg(CFG_LAST_ROW, lr);
        settings_used++;
        // Now and then the previous scan simply carries on under the new geometry.
        if ($urandom_range(4) != 0) send_request(MODE_START, 1'b1, 1'b0, '0);
        quota = $urandom_range(6, 60);
        after_done = 0;
        for (int i = 0; i < quota && after_done < 3; i++) begin
            if (i == quota / 2 && $urandom_range(5) == 0) begin
                wait_idle();
                if ($urandom_range(1) == 0) write_reg(CFG_LAST_COLUMN, $urandom_range(255));
                else write_reg(CFG_LAST_ROW, $urandom_range(249));
                settings_used++;
            end
            send_request(($urandom_range(29) == 0) ? MODE_START : MODE_NEXT,
                         $urandom_range(19) != 0, 1'b0, '0);
            if (last_result.scan_done) after_done++;
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        block_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end else begin
                want = expected_blocks.pop_front();
                check_field("col_first", want.col_first, m_axis_tdata[7:0]);
                check_field("col_second", want.col_second, m_axis_tdata[15:8]);
                check_field("col_count", want.col_count, m_axis_tdata[17:16]);
                check_field("row_first", want.row_first, m_axis_tdata[25:18]);
                check_field("row_last", want.row_last, m_axis_tdata[33:26]);
                check_field("block_valid", want.block_valid, m_axis_tuser);
                check_field("scan_done", want.scan_done, m_axis_tlast);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int directed_count;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        mismatches    = 0;
        requests_sent = 0;
        blocks_predicted = 0;
        scan_ends_seen = 0;
        settings_used = 0;
        reg_dev    = DEV_UNKNOWN;
        reg_col_lo = 8'd0;
        reg_col_hi = 8'd255;
        reg_row_lo = 8'd0;
        reg_row_hi = 8'd249;
        scan_state = PH_IDLE;
        stripe_idx = 8'd0;
        rowblk_idx = 8'd0;

        plan = '{
            // Out of reset the scan is finished and the device type is unknown.
            idle_row(MODE_NEXT, 1'b1, 1'b1),
            reg_row(CFG_DEVICE_TYPE, DEV_VERTEX),
            idle_row(MODE_START, 1'b1, 1'b0),
            known_row(MODE_NEXT, 1'b1, 0, 2, 2, 0, 2, 1'b0),
            // Small vertex rectangle: main block, right strip, bottom strip, corner.
            reg_row(CFG_FIRST_COLUMN, 8'd0),
            reg_row(CFG_LAST_COLUMN, 8'd5),
            reg_row(CFG_FIRST_ROW, 8'd0),
            reg_row(CFG_LAST_ROW, 8'd3),
            idle_row(MODE_START, 1'b1, 1'b0),
            known_row(MODE_NEXT, 1'b1, 0, 2, 2, 0, 2, 1'b0),
            known_row(MODE_NEXT, 1'b1, 4, 0, 1, 0, 2, 1'b0),
            known_row(MODE_NEXT, 1'b1, 0, 2, 2, 3, 3, 1'b0),
            known_row(MODE_NEXT, 1'b1, 4, 0, 1, 3, 3, 1'b1),
            // keep_going low at the end of a stripe: block given, then nothing.
            idle_row(MODE_START, 1'b0, 1'b0),
            known_row(MODE_NEXT, 1'b0, 0, 2, 2, 0, 2, 1'b1),
            // Outer mode at the bottom right corner of the matrix.
            reg_row(CFG_DEVICE_TYPE, DEV_OUTER),
            reg_row(CFG_FIRST_COLUMN, 8'd250),
            reg_row(CFG_LAST_COLUMN, 8'd255),
            reg_row(CFG_FIRST_ROW, 8'd246),
            reg_row(CFG_LAST_ROW, 8'd249),
            idle_row(MODE_START, 1'b1, 1'b0),
            known_row(MODE_NEXT, 1'b1, 250, 0, 1, 246, 247, 1'b0),
            known_row(MODE_NEXT, 1'b0, 250, 0, 1, 248, 249, 1'b1),
            // keep_going is ignored on the stripe at the matrix edge.
            req_row(MODE_START, 1'b1),
            req_row(MODE_NEXT, 1'b1),
            req_row(MODE_NEXT, 1'b1),
            req_row(MODE_NEXT, 1'b1),
            req_row(MODE_NEXT, 1'b1),
            req_row(MODE_NEXT, 1'b0),
            known_row(MODE_NEXT, 1'b0, 254, 0, 1, 248, 249, 1'b1),
            // Stripes without row blocks abort inside the request that passes them.
            reg_row(CFG_DEVICE_TYPE, DEV_VERTEX),
            reg_row(CFG_FIRST_COLUMN, 8'd0),
            reg_row(CFG_LAST_COLUMN, 8'd7),
            reg_row(CFG_FIRST_ROW, 8'd5),
            reg_row(CFG_LAST_ROW, 8'd5),
            idle_row(MODE_START, 1'b1, 1'b0),
            idle_row(MODE_NEXT, 1'b0, 1'b1),
            // Wrapped column range: the tail pair wraps below column zero.
            reg_row(CFG_FIRST_COLUMN, 8'd3),
            reg_row(CFG_LAST_COLUMN, 8'd1),
            reg_row(CFG_LAST_ROW, 8'd7),
            req_row(MODE_START, 1'b1),
            reg_row(CFG_DEVICE_TYPE, DEV_RESERVED),
            idle_row(MODE_NEXT, 1'b1, 1'b1),
            reg_row(CFG_DEVICE_TYPE, DEV_VERTEX),
            req_row(MODE_START, 1'b1),
            known_row(MODE_NEXT, 1'b1, 255, 1, 2, 5, 7, 1'b1),
            reg_row(CFG_DEVICE_TYPE, DEV_UNKNOWN),
            idle_row(MODE_START, 1'b1, 1'b1)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_request(plan[i].mode, plan[i].kg, plan[i].typed, plan[i].want);
            end
        end
        directed_count = requests_sent;

        for (int sid = 0; requests_sent < directed_count + RANDOM_REQUESTS; sid++)
            run_session(sid);

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests under %0d register settings across all idle patterns.",
                 requests_sent, settings_used);
        $display("Predicted %0d injection blocks and %0d end-of-scan flags.",
                 blocks_predicted, scan_ends_seen);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pbis_pkg.sv
rtl/pbis_geom.sv
rtl/pbis_step.sv
rtl/pixel_block_injection_scanner_top.sv
tb/tb_top.sv
